### design/tfi_pkg.sv
// package for the tabulated field interpolation unit
// types, constants and arithmetic helpers shared by all modules
package tfi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = 11;
  localparam int DIV_W = 50;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ATOM  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [9:0]        entry_index;
    logic signed [31:0] entry_position;
    logic signed [31:0] entry_potential;
    logic signed [31:0] entry_gradient;
    logic signed [31:0] atom_position;
    logic signed [31:0] atom_charge;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_out;
    logic signed [47:0] energy_total;
    logic signed [47:0] force_total;
    logic               out_of_range;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_CLEAR, ST_NONE,
    ST_RD0, ST_RD0W, ST_DIV1, ST_DIV1W, ST_CHK,
    ST_RDB, ST_RDBW, ST_DIV2, ST_DIV2W,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_ACC, ST_OUT
  } state_t;

  typedef struct packed {
    logic cap_in;
    logic wr_tab;
    logic clr;
    logic rd0;
    logic rdb;
    logic cap0;
    logic capb;
    logic div1_start;
    logic div2_start;
    logic cap_bin;
    logic cap_frac;
    logic m1;
    logic m2;
    logic m3;
    logic m4;
    logic m5;
    logic m6;
    logic acc;
    logic oor;
    logic zero_res;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic bad_bin;
    logic out_busy;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] prod;
    logic signed [65:0] p;
    prod = a * b;
    p = 66'(prod) + 66'sd32768;
    return sat32(p >>> 16);
  endfunction

endpackage

### design/tfi_if.sv
// valid/ready channel interfaces for the interpolation unit
// depends on tfi_pkg
interface tfi_in_if;
  import tfi_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfi_out_if;
  import tfi_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/tfi_divider.sv
// iterative signed divider, one quotient bit a cycle, truncates toward zero
// depends on tfi_pkg
module tfi_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [tfi_pkg::DIV_W-1:0] num,
  input  logic signed [tfi_pkg::DIV_W-1:0] den,
  output logic done,
  output logic signed [tfi_pkg::DIV_W-1:0] quo
);
  import tfi_pkg::*;

  logic [DIV_W-1:0] q;
  logic [DIV_W-1:0] d;
  logic [DIV_W:0]   r;
  logic             neg;
  logic             busy;
  logic [5:0]       cnt;
  logic [DIV_W:0]   trial;

  assign trial = {r[DIV_W-1:0], q[DIV_W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'(DIV_W);
        q <= num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
        d <= den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
        neg <= num[DIV_W-1] ^ den[DIV_W-1];
        r <= '0;
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          r <= trial;
          q <= {q[DIV_W-2:0], 1'b1};
        end else begin
          r <= {r[DIV_W-1:0], q[DIV_W-1]};
          q <= {q[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);
endmodule

### design/tfi_datapath.sv
// datapath: table memories, divider, multiply chain, sums and result register
// depends on tfi_pkg, tfi_if and tfi_divider
module tfi_datapath (
  input  logic clk,
  input  logic rst,
  input  tfi_pkg::in_item_t in_data,
  input  logic [tfi_pkg::CNT_W-1:0] table_count,
  input  tfi_pkg::cmd_t cmd,
  output tfi_pkg::stat_t stat,
  tfi_out_if.source res
);
  import tfi_pkg::*;

  logic signed [31:0] pos_mem [TABLE_DEPTH];
  logic signed [31:0] pot_mem [TABLE_DEPTH];
  logic signed [31:0] frc_mem [TABLE_DEPTH];

  in_item_t           item;
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] rpos, rpot, rfrc;
  logic signed [31:0] pos0, pos1, posb, posb1;
  logic signed [31:0] potb, potb1, frcb, frcb1;
  logic               rd_hi;
  logic signed [DIV_W-1:0] bin, frac_q;
  logic signed [31:0] frac;
  logic signed [31:0] fbase, pbase, fslope, pslope, fterm, pterm, fval, pval;
  logic signed [47:0] esum, fsum;
  logic [CNT_W-1:0]   cnt;
  logic               div_start, div_done;
  logic signed [DIV_W-1:0] div_num, div_den, div_quo;
  logic               second;
  logic signed [31:0] gneg;
  logic signed [48:0] es_n, fs_n;

  assign gneg = (item.entry_gradient == 32'sh80000000) ? 32'sh7fffffff
              : -item.entry_gradient;

  always_ff @(posedge clk) begin
    if (cmd.wr_tab) begin
      pos_mem[item.entry_index] <= item.entry_position;
      pot_mem[item.entry_index] <= item.entry_potential;
      frc_mem[item.entry_index] <= gneg;
    end
    rpos <= pos_mem[rd_addr];
    rpot <= pot_mem[rd_addr];
    rfrc <= frc_mem[rd_addr];
  end

  always_comb begin
    cnt = table_count;
    if (table_count < CNT_W'(2)) cnt = CNT_W'(2);
    if (table_count > CNT_W'(TABLE_DEPTH)) cnt = CNT_W'(TABLE_DEPTH);
  end

  always_comb begin
    if (cmd.rd0) rd_addr = rd_hi ? IDX_W'(1) : '0;
    else rd_addr = rd_hi ? IDX_W'(bin) + IDX_W'(1) : IDX_W'(bin);
  end

  assign div_start = cmd.div1_start | cmd.div2_start;
  always_comb begin
    if (cmd.div1_start) begin
      div_num = DIV_W'(item.atom_position) - DIV_W'(pos0);
      div_den = DIV_W'(pos1) - DIV_W'(pos0);
    end else begin
      div_num = (DIV_W'(item.atom_position) - DIV_W'(posb)) <<< 16;
      div_den = DIV_W'(posb1) - DIV_W'(posb);
    end
  end

  tfi_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign stat.div_done = div_done;
  assign stat.bad_bin = (pos1 == pos0) || bin[DIV_W-1] ||
                        (bin > DIV_W'(cnt) - DIV_W'(2));
  assign stat.out_busy = res.valid && !res.ready;

  assign es_n = 49'(esum) + 49'(pval);
  assign fs_n = 49'(fsum) + 49'(fval);

  always_ff @(posedge clk) begin
    if (rst) begin
      esum <= '0;
      fsum <= '0;
      res.valid <= 1'b0;
      rd_hi <= 1'b0;
      second <= 1'b0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      if (cmd.cap_in) item <= in_data;
      if (cmd.rd0 || cmd.rdb) rd_hi <= !rd_hi;
      if (cmd.cap0) begin
        second <= !second;
        if (!second) pos0 <= rpos;
        else pos1 <= rpos;
      end
      if (cmd.capb) begin
        second <= !second;
        if (!second) begin
          posb <= rpos; potb <= rpot; frcb <= rfrc;
        end else begin
          posb1 <= rpos; potb1 <= rpot; frcb1 <= rfrc;
        end
      end
      if (cmd.cap_bin) bin <= div_quo;
      if (cmd.cap_frac) frac_q <= div_quo;
      if (cmd.m1) frac <= (posb1 == posb) ? 32'sd0 : sat32(66'(frac_q));
      if (cmd.m2) begin
        fbase <= qmul(item.atom_charge, frcb);
        pbase <= qmul(item.atom_charge, potb);
      end
      if (cmd.m3) fslope <= qmul(frac, sat32(66'(frcb1) - 66'(frcb)));
      if (cmd.m4) pslope <= qmul(frac, sat32(66'(potb1) - 66'(potb)));
      if (cmd.m5) begin
        fterm <= qmul(fslope, item.atom_charge);
        pterm <= qmul(pslope, item.atom_charge);
      end
      if (cmd.m6) begin
        fval <= sat32(66'(fbase) + 66'(fterm));
        pval <= sat32(66'(pbase) + 66'(pterm));
      end
      if (cmd.acc) begin
        esum <= (es_n > 49'sh0_7fff_ffff_ffff) ? 48'sh7fff_ffff_ffff :
                (es_n < -49'sh0_8000_0000_0000) ? 48'sh8000_0000_0000 : es_n[47:0];
        fsum <= (fs_n > 49'sh0_7fff_ffff_ffff) ? 48'sh7fff_ffff_ffff :
                (fs_n < -49'sh0_8000_0000_0000) ? 48'sh8000_0000_0000 : fs_n[47:0];
      end
      if (cmd.clr) begin
        esum <= '0;
        fsum <= '0;
      end
      if (cmd.out_load) begin
        res.valid <= 1'b1;
        res.data.force_out <= cmd.zero_res ? 32'sd0 : fval;
        res.data.energy_total <= esum;
        res.data.force_total <= fsum;
        res.data.out_of_range <= cmd.oor;
      end
    end
  end
endmodule

### design/tfi_controller.sv
// controller state machine sequencing loads, clears and atom evaluation
// depends on tfi_pkg
module tfi_controller (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [1:0] in_kind,
  output logic in_ready,
  input  tfi_pkg::stat_t stat,
  output tfi_pkg::cmd_t cmd
);
  import tfi_pkg::*;

  state_t state, state_next;
  logic   oor, oor_next;
  logic   atom, atom_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      oor <= 1'b0;
      atom <= 1'b0;
    end else begin
      state <= state_next;
      oor <= oor_next;
      atom <= atom_next;
    end
  end

  always_comb begin
    state_next = state;
    oor_next = oor;
    atom_next = atom;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          oor_next = 1'b0;
          atom_next = 1'b0;
          unique case (kind_t'(in_kind))
            KIND_LOAD:  state_next = ST_LOAD;
            KIND_ATOM: begin
              atom_next = 1'b1;
              state_next = ST_RD0;
            end
            KIND_CLEAR: state_next = ST_CLEAR;
            default:    state_next = ST_NONE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.wr_tab = 1'b1;
        state_next = ST_OUT;
      end
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        state_next = ST_OUT;
      end
      ST_NONE: state_next = ST_OUT;
      ST_RD0: begin
        cmd.rd0 = 1'b1;
        state_next = ST_RD0W;
      end
      ST_RD0W: begin
        cmd.rd0 = 1'b1;
        cmd.cap0 = 1'b1;
        state_next = ST_DIV1;
      end
      ST_DIV1: begin
        cmd.cap0 = 1'b1;
        state_next = ST_DIV1W;
      end
      ST_DIV1W: begin
        cmd.div1_start = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (stat.div_done) begin
          cmd.cap_bin = 1'b1;
          state_next = ST_RDB;
        end
      end
      ST_RDB: begin
        if (stat.bad_bin) begin
          oor_next = 1'b1;
          state_next = ST_OUT;
        end else begin
          cmd.rdb = 1'b1;
          state_next = ST_RDBW;
        end
      end
      ST_RDBW: begin
        cmd.rdb = 1'b1;
        cmd.capb = 1'b1;
        state_next = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.capb = 1'b1;
        state_next = ST_DIV2W;
      end
      ST_DIV2W: begin
        cmd.div2_start = 1'b1;
        state_next = ST_M1;
      end
      ST_M1: begin
        if (stat.div_done) begin
          cmd.cap_frac = 1'b1;
          state_next = ST_M2;
        end
      end
      ST_M2: begin
        cmd.m1 = 1'b1;
        cmd.m2 = 1'b1;
        state_next = ST_M3;
      end
      ST_M3: begin
        cmd.m3 = 1'b1;
        state_next = ST_M4;
      end
      ST_M4: begin
        cmd.m4 = 1'b1;
        state_next = ST_M5;
      end
      ST_M5: begin
        cmd.m5 = 1'b1;
        state_next = ST_M6;
      end
      ST_M6: begin
        cmd.m6 = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.oor = oor;
          cmd.zero_res = oor || !atom;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

### design/tabulated_field_interpolation_unit.sv
// top level of the tabulated field interpolation unit
// depends on tfi_pkg, tfi_if, tfi_controller and tfi_datapath
//
//  channel  dir  payload
//  in       in   kind, entry fields, atom fields (valid/ready)
//  res      out  force_out, energy_total, force_total, out_of_range
//  cfg      in   cfg_we, cfg_data (table_count)
//
// load, clear and unknown items go from ST_IDLE through their own state to ST_OUT; an atom
// makes two passes through the shared serial divider
// an atom outside the table ends after the first division
// a held result stalls only the next item's result write, not its acceptance
// rst is synchronous; sums clear to zero and table_count to 2, tables hold
module tabulated_field_interpolation_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [tfi_pkg::CNT_W-1:0] cfg_data,
  tfi_in_if.sink in,
  tfi_out_if.source res
);
  import tfi_pkg::*;

  logic [CNT_W-1:0] table_count;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) table_count <= CNT_W'(2);
    else if (cfg_we) table_count <= cfg_data;
  end

  tfi_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_kind(in.data.kind),
    .in_ready(in.ready), .stat(stat), .cmd(cmd)
  );

  tfi_datapath u_dp (
    .clk(clk), .rst(rst), .in_data(in.data), .table_count(table_count),
    .cmd(cmd), .stat(stat), .res(res)
  );
endmodule

### dv/tabulated_field_interpolation_unit_tb.sv
`timescale 1ns / 100ps
// testbench for the tabulated field interpolation unit: a directed table and
// random phases, each result checked against a Q16.16 predictor or a given value
// depends on tfi_pkg, tfi_if and the unit's top level
module tabulated_field_interpolation_unit_tb;
  import tfi_pkg::*;

  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam longint MAX48 = 64'sd140737488355327;
  localparam longint MIN48 = -64'sd140737488355328;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    in_item_t it;
    bit given;
    out_item_t res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CNT_W-1:0] cfg_data = '0;

  tfi_in_if in_ch ();
  tfi_out_if res_ch ();

  tabulated_field_interpolation_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in(in_ch.sink), .res(res_ch.source)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor state
  longint tab_pos [TABLE_DEPTH];
  longint tab_pot [TABLE_DEPTH];
  longint tab_frc [TABLE_DEPTH];
  bit loaded [TABLE_DEPTH];
  longint energy_acc, force_acc;
  int count_reg;

  out_item_t expect_q [$];
  row_t given_q [$];
  int errs = 0;
  bit quiet = 0;
  bit hold_req = 0;
  int cycles = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return clamp((a * b + 64'sd32768) >>> 16, MIN32, MAX32);
  endfunction

  function automatic longint lerp_scaled(longint lo_v, longint hi_v, longint frac,
                                         longint q);
    longint base, slope, term;
    base = q_mul(q, lo_v);
    slope = q_mul(frac, clamp(hi_v - lo_v, MIN32, MAX32));
    term = q_mul(slope, q);
    return clamp(base + term, MIN32, MAX32);
  endfunction

  function automatic out_item_t predict_field(in_item_t it);
    out_item_t r;
    longint x, q, cnt, dz, bin, span, frac, f, pot;
    bit oor;
    f = 0;
    oor = 0;
    if (it.kind == KIND_LOAD) begin
      tab_pos[it.entry_index] = longint'(it.entry_position);
      tab_pot[it.entry_index] = longint'(it.entry_potential);
      tab_frc[it.entry_index] = clamp(-longint'(it.entry_gradient), MIN32, MAX32);
    end else if (it.kind == KIND_CLEAR) begin
      energy_acc = 0;
      force_acc = 0;
    end else if (it.kind == KIND_ATOM) begin
      x = longint'(it.atom_position);
      q = longint'(it.atom_charge);
      cnt = clamp(count_reg, 2, TABLE_DEPTH);
      dz = tab_pos[1] - tab_pos[0];
      bin = -1;
      if (dz != 0) bin = (x - tab_pos[0]) / dz;
      if (dz == 0 || bin < 0 || bin > cnt - 2) begin
        oor = 1;
      end else begin
        span = tab_pos[bin + 1] - tab_pos[bin];
        frac = 0;
        if (span != 0) frac = clamp((x - tab_pos[bin]) * 65536 / span, MIN32, MAX32);
        f = lerp_scaled(tab_frc[bin], tab_frc[bin + 1], frac, q);
        pot = lerp_scaled(tab_pot[bin], tab_pot[bin + 1], frac, q);
        energy_acc = clamp(energy_acc + pot, MIN48, MAX48);
        force_acc = clamp(force_acc + f, MIN48, MAX48);
      end
    end
    r.force_out = f[31:0];
    r.energy_total = energy_acc[47:0];
    r.force_total = force_acc[47:0];
    r.out_of_range = oor;
    return r;
  endfunction

  function automatic in_item_t mk(kind_t k, int idx, logic [31:0] ep, logic [31:0] epo,
                                  logic [31:0] eg, logic [31:0] ax, logic [31:0] aq);
    in_item_t it;
    it.kind = k;
    it.entry_index = idx[9:0];
    it.entry_position = ep;
    it.entry_potential = epo;
    it.entry_gradient = eg;
    it.atom_position = ax;
    it.atom_charge = aq;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic [31:0] f, logic [47:0] e, logic [47:0] t,
                                       logic o);
    out_item_t r;
    r.force_out = f;
    r.energy_total = e;
    r.force_total = t;
    r.out_of_range = o;
    return r;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    row_t g;
    out_item_t p, e;
    cycles <= cycles + 1;
    if (!rst && in_ch.valid && in_ch.ready) begin
      g = given_q.pop_front();
      p = predict_field(in_ch.data);
      expect_q.push_back(g.given ? g.res : p);
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expect_q.size() == 0) begin
        errs++;
        if (errs < 40) $error("result transaction with nothing expected");
      end else begin
        e = expect_q.pop_front();
        if (res_ch.data.force_out !== e.force_out) begin
          errs++;
          if (errs < 40) $error("force_out exp %h got %h", e.force_out, res_ch.data.force_out);
        end
        if (res_ch.data.energy_total !== e.energy_total) begin
          errs++;
          if (errs < 40)
            $error("energy_total exp %h got %h", e.energy_total, res_ch.data.energy_total);
        end
        if (res_ch.data.force_total !== e.force_total) begin
          errs++;
          if (errs < 40)
            $error("force_total exp %h got %h", e.force_total, res_ch.data.force_total);
        end
        if (res_ch.data.out_of_range !== e.out_of_range) begin
          errs++;
          if (errs < 40)
            $error("out_of_range exp %b got %b", e.out_of_range, res_ch.data.out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver with random stalls and one long hold
  initial begin
    res_ch.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        res_ch.ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send(in_item_t it, bit given, out_item_t r);
    row_t g;
    g.it = it;
    g.given = given;
    g.res = r;
    given_q.push_back(g);
    in_ch.valid <= 1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (expect_q.size() != 0 || given_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(int v);
    cfg_we <= 1;
    cfg_data <= v[CNT_W-1:0];
    @(posedge clk);
    count_reg = v;
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic load_entry(int idx, longint p0, longint dz, int mag);
    longint pos;
    out_item_t z;
    pos = p0 + idx * dz;
    if (idx >= 2 && $urandom_range(0, 7) == 0) pos = tab_pos[idx - 1];
    send(mk(KIND_LOAD, idx, pos[31:0], $urandom_range(0, 2 * mag) - mag,
            $urandom_range(0, 2 * mag) - mag, rnd32(), rnd32()), 0, z);
    loaded[idx] = 1;
  endtask

  task automatic run_phase(int cfg_val, int n_items);
    int eff, mag, sel;
    longint p0, dz, x, span, aspan;
    logic [31:0] q;
    out_item_t z;
    in_item_t it;
    eff = cfg_val < 2 ? 2 : (cfg_val > TABLE_DEPTH ? TABLE_DEPTH : cfg_val);
    drain();
    write_count(cfg_val);
    p0 = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    dz = $urandom_range(1 << 10, 1 << 20);
    if ($urandom_range(0, 3) == 0) dz = -dz;
    mag = $urandom_range(0, 1) ? (1 << 20) : 32'h7fffffff;
    for (int i = 0; i < eff; i++)
      if (!loaded[i] || i < 16 || eff <= 64) load_entry(i, p0, dz, mag);
    span = (tab_pos[1] - tab_pos[0]) * eff;
    aspan = span < 0 ? -span : span;
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
        x = longint'($urandom) % (aspan == 0 ? 1 : aspan);
        x = tab_pos[0] + (span < 0 ? -x : x);
        x = clamp(x, MIN32, MAX32);
        q = $urandom_range(0, 3) == 0 ? rnd32() : $urandom_range(0, 1 << 18) - (1 << 17);
        send(mk(KIND_ATOM, $urandom, rnd32(), rnd32(), rnd32(), x[31:0], q), 0, z);
      end else if (sel < 84) begin
        load_entry($urandom_range(1, eff - 1), p0, dz, mag);
      end else if (sel < 89) begin
        it = mk(KIND_CLEAR, $urandom, rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
        send(it, 0, z);
      end else if (sel < 93) begin
        it = mk(KIND_NONE, $urandom, rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
        send(it, 0, z);
      end else begin
        send(mk(KIND_ATOM, $urandom, rnd32(), rnd32(), rnd32(), rnd32(), rnd32()), 0, z);
      end
      if (n == 10 && cfg_val == 7) hold_req = 1;
    end
  endtask

  row_t dir_rows [$];

  initial begin
    row_t r;
    out_item_t zero, oor1;
    zero = mk_res(0, 0, 0, 0);
    oor1 = mk_res(0, 0, 0, 1);
    in_ch.valid = 0;
    in_ch.data = '0;
    energy_acc = 0;
    force_acc = 0;
    count_reg = 2;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tab_pos[i] = 0;
      tab_pot[i] = 0;
      tab_frc[i] = 0;
      loaded[i] = 0;
    end

    r.given = 1; r.res = zero;
    r.it = mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0); dir_rows.push_back(r);
    r.it = mk(KIND_NONE, 1023, '1, '1, '1, '1, '1); dir_rows.push_back(r);
    r.it = mk(KIND_LOAD, 0, 0, 0, 0, 0, 0); dir_rows.push_back(r);
    // zero first spacing, most negative gradient
    r.it = mk(KIND_LOAD, 1, 0, 32'h20000, 32'h80000000, 0, 0); dir_rows.push_back(r);
    r.res = oor1;
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, 0, 32'h10000); dir_rows.push_back(r);
    r.res = zero;
    r.it = mk(KIND_LOAD, 1, 32'h10000, 32'h20000, 32'h80000000, 0, 0); dir_rows.push_back(r);
    r.given = 0;
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, 32'h8000, 32'h10000); dir_rows.push_back(r);
    // below the first entry by less than a spacing: extrapolates
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, -32'sh8000, 32'h10000); dir_rows.push_back(r);
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, -32'sh10000, 32'h10000); dir_rows.push_back(r);
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, 32'h20000, 32'h10000); dir_rows.push_back(r);
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff); dir_rows.push_back(r);
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, 32'h80000000, 32'h80000000); dir_rows.push_back(r);
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, 32'hffff, 32'h80000000); dir_rows.push_back(r);
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, 0, 32'h7fffffff); dir_rows.push_back(r);
    r.it = mk(KIND_ATOM, 0, 0, 0, 0, 32'h4000, 32'h80000000); dir_rows.push_back(r);
    r.it = mk(KIND_LOAD, 1023, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0);
    dir_rows.push_back(r);
    r.it = mk(KIND_LOAD, 512, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    dir_rows.push_back(r);
    r.it = mk(KIND_NONE, 0, 0, 0, 0, 0, 0); dir_rows.push_back(r);
    r.given = 1; r.res = zero;
    r.it = mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0); dir_rows.push_back(r);

    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    loaded[0] = 1;
    loaded[1] = 1;
    loaded[512] = 1;
    loaded[1023] = 1;
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].given, dir_rows[i].res);

    run_phase(0, 40);
    run_phase(7, 70);
    run_phase(2047, 60);
    run_phase(1024, 50);
    run_phase(40, 60);
    run_phase(1, 20);
    quiet = 1;
    run_phase(3, 40);

    drain();
    repeat (200) @(posedge clk);
    if (errs == 0 && expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
